### hw/rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  localparam logic [6:0] PadChar = 7'h3D;

  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadOne  = 2'd1;
  localparam logic [1:0] PadTwo  = 2'd2;

  localparam logic [1:0] CharLast = 2'd3;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  pads;
    logic        last;
  } group_t;

  typedef struct packed {
    logic   valid;
    logic   full;
    group_t head;
  } queue_status_t;

  function automatic logic [6:0] sextet_to_char(input logic [5:0] s);
    logic [6:0] c;
    c = 7'h00;
    if (s < 6'd26) begin
      c = 7'(s) + 7'd65;
    end else if (s < 6'd52) begin
      c = 7'(s - 6'd26) + 7'd97;
    end else if (s < 6'd62) begin
      c = 7'(s - 6'd52) + 7'd48;
    end else if (s == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

### hw/rtl/base64_stream_encoder.sv
// Streaming Base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per item on data_byte_i, with final_byte_i
// marking the last byte of a message; accepted when in_valid_i is high and
// in_stall_o is low. Output channel: one ASCII character per item on
// out_char_o, with group_end_o on the fourth character of each group and
// message_end_o on the last character of the message; accepted when
// out_valid_o is high and out_stall_i is low.
// Every third byte, or a final byte, emits a group of four characters.
// With the serializer idle, the first character of a group is presented once
// the group is written into the queue and loaded into the output register;
// the rest follow one per cycle while out_stall_i is low. The output side sets
// the pace, so bytes are taken at up to one per cycle while the queue has room.
// A two-entry group queue sits between the byte packer and the character
// serializer; in_stall_o rises only while that queue is full.
// When the receiver stalls, the current character holds and the queue fills,
// then the input stalls. Reset clears the pending bytes, the queue and the
// output valid; nothing is emitted until new bytes arrive.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       group_end_o,
  output logic       message_end_o
);

  queue_status_t     qstat;
  group_t            push_group;
  logic              push;
  logic              pop;
  logic [1:0]        char_idx;
  logic [CountW-1:0] qcount;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .queue_full_i (qstat.full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .status_o     (qstat),
    .count_o      (qcount)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (qstat),
    .pop_o         (pop),
    .char_idx_o    (char_idx),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .group_end_o   (group_end_o),
    .message_end_o (message_end_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> group_end_o)
    else $error("message end without group end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_idx != 2'd0 |-> qstat.valid)
    else $error("serializer mid-group with empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount <= CountW'(QueueDepth))
    else $error("group queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !in_stall_o |=> qstat.valid)
    else $error("pushed group lost");
`endif

endmodule

### hw/rtl/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output group_t     push_group_o
);

  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] bytes_q, bytes_d;
  logic        accept;
  logic        complete;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign complete   = final_byte_i || (cnt_q >= 2'd2);
  assign push_o     = accept && complete;

  always_comb begin
    push_group_o.last = final_byte_i;
    unique case (cnt_q)
      2'd0: begin
        push_group_o.triple = {data_byte_i, 16'h0000};
        push_group_o.pads   = PadTwo;
      end
      2'd1: begin
        push_group_o.triple = {bytes_q[15:8], data_byte_i, 8'h00};
        push_group_o.pads   = PadOne;
      end
      default: begin
        push_group_o.triple = {bytes_q, data_byte_i};
        push_group_o.pads   = PadNone;
      end
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (accept) begin
      if (complete) begin
        cnt_d   = 2'd0;
        bytes_d = 16'h0000;
      end else if (cnt_q == 2'd0) begin
        cnt_d   = 2'd1;
        bytes_d = {data_byte_i, 8'h00};
      end else begin
        cnt_d   = 2'd2;
        bytes_d = {bytes_q[15:8], data_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      bytes_q <= 16'h0000;
    end else begin
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

### hw/rtl/b64e_queue.sv
module b64e_queue
  import b64e_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  group_t        push_group_i,
  input  logic          pop_i,
  output queue_status_t status_o,
  output logic [CountW-1:0] count_o
);

  group_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign do_push = push_i && (count_q != CountW'(QueueDepth));
  assign do_pop  = pop_i && (count_q != '0);

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == CountW'(QueueDepth));
  assign status_o.head  = mem_q[rd_ptr_q];
  assign count_o        = count_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

### hw/rtl/b64e_back.sv
module b64e_back
  import b64e_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t status_i,
  output logic          pop_o,
  output logic [1:0]    char_idx_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [6:0]    out_char_o,
  output logic          group_end_o,
  output logic          message_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       gend_q, gend_d;
  logic       mend_q, mend_d;
  logic       load;
  logic [5:0] sextet;
  logic       is_pad;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = status_i.head.triple[23:18];
      2'd1:    sextet = status_i.head.triple[17:12];
      2'd2:    sextet = status_i.head.triple[11:6];
      default: sextet = status_i.head.triple[5:0];
    endcase
  end

  always_comb begin
    unique case (status_i.head.pads)
      PadOne:  is_pad = (idx_q == CharLast);
      PadTwo:  is_pad = (idx_q >= 2'd2);
      default: is_pad = 1'b0;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    gend_d  = gend_q;
    mend_d  = mend_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = status_i.valid;
      if (status_i.valid) begin
        char_d = is_pad ? PadChar : sextet_to_char(sextet);
        gend_d = (idx_q == CharLast);
        mend_d = (idx_q == CharLast) && status_i.head.last;
        idx_d  = idx_q + 2'd1;
        pop_o  = (idx_q == CharLast);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    gend_q <= gend_d;
    mend_q <= mend_d;
  end

  assign char_idx_o    = idx_q;
  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign group_end_o   = gend_q;
  assign message_end_o = mend_q;

endmodule
